FILE: rtl/iprrt_pkg.sv
// Package for the I/O port range reservation table.
// Holds request/status types, the back-end state type and the front-to-back queue word; no dependencies.
package iprrt_pkg;

    typedef enum logic {
        ACT_RESERVE = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BUSY      = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EVAL,
        BK_APPLY
    } t_bstate;

    // Classified request: end is base + count at 17 bits (no wrap).
    typedef struct packed {
        t_action     action;
        logic [15:0] base;
        logic [7:0]  count;
        logic [16:0] range_end;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_queue_out;

endpackage

FILE: rtl/io_port_range_reservation_table.sv
// I/O port range reservation table, top level: request queue front end
// plus table back end. Depends on iprrt_pkg, iprrt_front, iprrt_back.
// The table takes one request at a time through its evaluate and apply states;
// the front-end queue holds further requests meanwhile.
// Reset: synchronous, clears slot valid bits, used count, queue and result valid bit.
// Slot base/count storage is not cleared; it is only read behind a valid bit.
module io_port_range_reservation_table
    import iprrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [15:0] i_range_base,
    input  logic [7:0]  i_range_count,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [4:0]  o_entries_used
);

    t_queue_out q_word;
    logic       q_pop;

    // Front end: compute range end at 17 bits and buffer up to two requests;
    // the requester is held only while both queue words are in use.
    iprrt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_range_base  (i_range_base),
        .i_range_count (i_range_count),
        .o_q           (q_word),
        .i_pop         (q_pop)
    );

    // Back end: the evaluate state compares the request against every slot and
    // registers free/busy/match vectors; the apply state, once the result register
    // is free, picks the lowest slot, updates the table and loads the result
    // register. The next request is pulled as the apply state completes, so it sees the updated table.
    iprrt_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q            (q_word),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_entries_used (o_entries_used)
    );

endmodule

FILE: rtl/iprrt_front.sv
// Front end of the port range reservation table: accepts and classifies
// requests and holds them in a two-word queue. Depends on iprrt_pkg.
module iprrt_front
    import iprrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [15:0] i_range_base,
    input  logic [7:0]  i_range_count,
    output t_queue_out  o_q,
    input  logic        i_pop
);

    t_req       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_req       cls;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != 2'd0);

    always_comb begin
        cls.action    = t_action'(i_action);
        cls.base      = i_range_base;
        cls.count     = i_range_count;
        cls.range_end = {1'b0, i_range_base} + {9'd0, i_range_count};
    end

    assign o_q.valid = (r_cnt != 2'd0);
    assign o_q.req   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count out of range");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("push did not grow queue");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> r_cnt == $past(r_cnt) - 2'd1)
        else $error("pop did not shrink queue");

endmodule

FILE: rtl/iprrt_back.sv
// Back end of the port range reservation table: slot cells, overlap and
// match compares, slot update and the result register. Depends on iprrt_pkg.
module iprrt_back
    import iprrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_queue_out i_q,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [4:0] o_entries_used
);

    localparam int UW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (UW > 5) ? UW : 5;

    t_bstate r_state, n_state;
    t_req    r_req;

    logic [MAX_ENTRIES-1:0] r_slot_valid;
    logic [15:0]            r_slot_base  [MAX_ENTRIES];
    logic [7:0]             r_slot_count [MAX_ENTRIES];
    logic [16:0]            r_slot_end   [MAX_ENTRIES];

    logic [MAX_ENTRIES-1:0] busy_vec, match_vec;
    logic [MAX_ENTRIES-1:0] r_free, r_busy, r_match;
    logic [MAX_ENTRIES-1:0] free_oh, match_oh;
    logic [UW-1:0]          r_used, n_used;
    logic [CW-1:0]          used_w;

    logic    r_out_valid;
    t_status r_status;
    logic [4:0] r_used_out;

    logic    apply_go;
    t_status res_status;
    logic    do_reserve, do_release;

    // Per-slot compares, one cell each.
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            busy_vec[i]  = r_slot_valid[i] && (r_req.count != 8'd0)
                        && (r_slot_count[i] != 8'd0)
                        && ({1'b0, r_req.base} < r_slot_end[i])
                        && ({1'b0, r_slot_base[i]} < r_req.range_end);
            match_vec[i] = r_slot_valid[i] && (r_slot_base[i] == r_req.base)
                        && (r_slot_count[i] == r_req.count);
        end
    end

    // Lowest set bit isolation.
    assign free_oh  = r_free & (~r_free + 1'b1);
    assign match_oh = r_match & (~r_match + 1'b1);

    always_comb begin
        res_status = ST_OK;
        do_reserve = 1'b0;
        do_release = 1'b0;
        if (r_req.action == ACT_RESERVE) begin
            if (r_free == '0) begin
                res_status = ST_FULL;
            end else if (r_busy != '0) begin
                res_status = ST_BUSY;
            end else begin
                do_reserve = 1'b1;
            end
        end else begin
            if (r_match == '0) begin
                res_status = ST_NOT_FOUND;
            end else begin
                do_release = 1'b1;
            end
        end
    end

    assign apply_go = (r_state == BK_APPLY) && (!r_out_valid || !i_stall);
    assign o_pop    = i_q.valid && ((r_state == BK_IDLE) || apply_go);

    always_comb begin
        n_used = r_used;
        if (do_reserve)      n_used = r_used + 1'b1;
        else if (do_release) n_used = r_used - 1'b1;
    end

    assign used_w = CW'(n_used);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE:  if (o_pop) n_state = BK_EVAL;
            BK_EVAL:  n_state = BK_APPLY;
            BK_APPLY: begin
                if (apply_go) n_state = o_pop ? BK_EVAL : BK_IDLE;
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_slot_valid <= '0;
            r_used       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (apply_go) begin
                r_out_valid <= 1'b1;
                r_used      <= n_used;
                if (do_reserve) r_slot_valid <= r_slot_valid | free_oh;
                if (do_release) r_slot_valid <= r_slot_valid & ~match_oh;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_req <= i_q.req;
        if (r_state == BK_EVAL) begin
            r_free  <= ~r_slot_valid;
            r_busy  <= busy_vec;
            r_match <= match_vec;
        end
        if (apply_go) begin
            r_status   <= res_status;
            r_used_out <= (used_w > CW'(31)) ? 5'd31 : used_w[4:0];
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (apply_go && do_reserve && free_oh[i]) begin
                r_slot_base[i]  <= r_req.base;
                r_slot_count[i] <= r_req.count;
                r_slot_end[i]   <= r_req.range_end;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_entries_used = r_used_out;

    a_used_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == UW'($countones(r_slot_valid)))
        else $error("used count out of step with valid bits");

    a_full_all_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (apply_go && res_status == ST_FULL) |-> (&r_slot_valid))
        else $error("full reported with a free slot");

    a_reserve_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (apply_go && do_reserve) |=> r_used == $past(r_used) + 1'b1)
        else $error("reserve did not take a slot");

    a_eval_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == BK_EVAL)
        else $error("popped request not evaluated");

endmodule

FILE: verif/tb_io_port_range_reservation_table.sv
// Testbench for io_port_range_reservation_table: directed and random request words
// checked against a behavioral table predictor. Depends on iprrt_pkg and the RTL top.
module tb_io_port_range_reservation_table;
    timeunit 1ns;
    timeprecision 1ps;

    import iprrt_pkg::*;

    localparam int TB_SLOTS     = 16;
    localparam int QUIET_LIMIT  = 1000;  // cycles with no handshake on either channel
    localparam int DRAIN_CYCLES = 12;    // extra edges waited after the last reply to catch stray words
    localparam int MAX_REPORTS  = 10;

    // One predicted reply word: status plus occupied-slot count after the request.
    typedef struct packed {
        t_status    status;
        logic [4:0] used;
    } t_table_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [15:0] i_range_base;
    logic [7:0]  i_range_count;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [4:0]  o_entries_used;

    // Predictor copy of the reservation table.
    logic        tbl_valid [TB_SLOTS];
    logic [15:0] tbl_base  [TB_SLOTS];
    logic [7:0]  tbl_count [TB_SLOTS];

    t_table_reply expected_replies [$];
    int           fail_count;
    bit           tx_no_idle;
    bit           rx_no_idle;

    io_port_range_reservation_table #(
        .MAX_ENTRIES(TB_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_range_base   (i_range_base),
        .i_range_count  (i_range_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_entries_used (o_entries_used)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int slots_in_use();
        int n;
        n = 0;
        for (int i = 0; i < TB_SLOTS; i++) begin
            if (tbl_valid[i]) n++;
        end
        return n;
    endfunction

    // Applies one request to the table copy and returns the reply it must produce.
    // Ends are formed at 17 bits so a range near 0xFFFF never wraps to port 0.
    function automatic t_table_reply predict_table_reply(t_action act, logic [15:0] b,
                                                         logic [7:0] c);
        t_table_reply r;
        int           free_slot;
        bit           hit;
        int           n;
        logic [16:0]  b_end;
        logic [16:0]  s_end;
        r.status  = ST_OK;
        free_slot = -1;
        hit       = 1'b0;
        b_end     = {1'b0, b} + {9'd0, c};
        if (act == ACT_RESERVE) begin
            for (int i = 0; i < TB_SLOTS; i++) begin
                s_end = {1'b0, tbl_base[i]} + {9'd0, tbl_count[i]};
                if (!tbl_valid[i]) begin
                    if (free_slot < 0) free_slot = i;
                end else if (c != 8'd0 && tbl_count[i] != 8'd0 &&
                             {1'b0, b} < s_end && {1'b0, tbl_base[i]} < b_end) begin
                    hit = 1'b1;
                end
            end
            // full wins over busy: overlap is ignored once every slot is taken
            if (free_slot < 0) begin
                r.status = ST_FULL;
            end else if (hit) begin
                r.status = ST_BUSY;
            end else begin
                tbl_valid[free_slot] = 1'b1;
                tbl_base[free_slot]  = b;
                tbl_count[free_slot] = c;
            end
        end else begin
            // exact base and count; lowest matching slot goes first
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < TB_SLOTS; i++) begin
                if (r.status == ST_NOT_FOUND && tbl_valid[i] &&
                    tbl_base[i] == b && tbl_count[i] == c) begin
                    tbl_valid[i] = 1'b0;
                    r.status     = ST_OK;
                end
            end
        end
        n = slots_in_use();
        if (n > 31) n = 31;
        r.used = 5'(n);
        return r;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------
    // Request side: one word per call, random lead-in gap, then hold until taken.
    // Called at a rising edge; returns at the edge the word was accepted.
    // ------------------------------------------------------------------
    task automatic issue_word(t_action act, logic [15:0] b, logic [7:0] c);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= act;
        i_range_base  <= b;
        i_range_count <= c;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        expected_replies.push_back(predict_table_reply(act, b, c));
    endtask

    // ------------------------------------------------------------------
    // Result side: check each accepted word, then stall for a random count unless rx_no_idle is set.
    // ------------------------------------------------------------------
    initial begin : reply_monitor
        int           hold;
        t_table_reply want;
        hold = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
                if (expected_replies.size() == 0) begin
                    note_failure($sformatf("reply with nothing outstanding: status %0d used %0d",
                                           o_status, o_entries_used));
                end else begin
                    want = expected_replies.pop_front();
                    if (o_status !== want.status)
                        note_failure($sformatf("status mismatch: expected %0d got %0d",
                                               want.status, o_status));
                    if (o_entries_used !== want.used)
                        note_failure($sformatf("entries_used mismatch: expected %0d got %0d",
                                               want.used, o_entries_used));
                end
                hold = rx_no_idle ? 0 : $urandom_range(0, 15);
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Ends the run when neither channel moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) ||
                (o_valid === 1'b1 && i_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("io_port_range_reservation_table regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, zero-length ranges, top-of-space ends, adjacency and
    // ranges that start below a stored one and run into it.
    task automatic test_edge_ranges();
        issue_word(ACT_RELEASE, 16'h0000, 8'h00);  // empty table: not found
        issue_word(ACT_RESERVE, 16'h0000, 8'h00);  // zero length still takes a slot
        issue_word(ACT_RESERVE, 16'h0000, 8'h00);  // and never overlaps, even a twin
        issue_word(ACT_RELEASE, 16'h0000, 8'h00);  // lowest twin removed
        issue_word(ACT_RESERVE, 16'hFFFF, 8'hFF);  // end past 0xFFFF, no wrap
        issue_word(ACT_RESERVE, 16'h0000, 8'hFF);  // must not hit the top range
        issue_word(ACT_RESERVE, 16'hFF01, 8'hFF);  // runs into top range from below
        issue_word(ACT_RESERVE, 16'h00FF, 8'h01);  // adjacent above 0x0000..0x00FE
        issue_word(ACT_RESERVE, 16'h1000, 8'h10);
        issue_word(ACT_RESERVE, 16'h0FF0, 8'h11);  // starts below, overlaps by one
        issue_word(ACT_RESERVE, 16'h0FF0, 8'h10);  // adjacent below
        issue_word(ACT_RESERVE, 16'h1008, 8'h00);  // zero length inside a stored range
        issue_word(ACT_RELEASE, 16'h1000, 8'h0F);  // count differs: not found
        issue_word(ACT_RELEASE, 16'h1001, 8'h10);  // base differs: not found
        issue_word(ACT_RELEASE, 16'h1000, 8'h10);
        issue_word(ACT_RELEASE, 16'hFFFF, 8'hFF);
    endtask

    // Fill every slot, then check that full is reported ahead of busy.
    task automatic test_full_table();
        logic [15:0] b;
        b = 16'h4000;
        while (slots_in_use() < TB_SLOTS) begin
            issue_word(ACT_RESERVE, b, 8'h80);
            b = b + 16'h0100;
        end
        issue_word(ACT_RESERVE, 16'h4000, 8'h80);  // overlapping but full
        issue_word(ACT_RESERVE, 16'h2000, 8'h00);  // zero length, still full
        issue_word(ACT_RELEASE, 16'h4000, 8'h80);
        issue_word(ACT_RESERVE, 16'h40F0, 8'h20);  // runs into 0x4100: busy
        issue_word(ACT_RESERVE, 16'h4000, 8'h80);  // fills the freed slot
    endtask

    // Reserves crowded into a small window and releases of stored
    // ranges, with near-miss releases and fully random words mixed in.
    task automatic test_random_traffic();
        t_action     act;
        logic [15:0] b;
        logic [7:0]  c;
        logic [15:0] window;
        int          pick;
        int          rel_share;
        int          sel;
        int          live [$];
        for (int phase = 0; phase < 8; phase++) begin
            tx_no_idle = (phase % 4 == 1) || (phase % 4 == 3);
            rx_no_idle = (phase % 4 == 2) || (phase % 4 == 3);
            window     = (phase == 2) ? 16'hFC00 : 16'($urandom_range(0, 16'hFFFF));
            for (int k = 0; k < 100; k++) begin
                live.delete();
                for (int i = 0; i < TB_SLOTS; i++) begin
                    if (tbl_valid[i]) live.push_back(i);
                end
                // drain harder when the table is close to full
                rel_share = (live.size() >= 12) ? 45 : 25;
                pick      = $urandom_range(0, 99);
                if (pick < 10) begin
                    act = t_action'(1'($urandom));
                    b   = 16'($urandom);
                    c   = 8'($urandom);
                end else if (pick < 10 + rel_share + 8 && live.size() > 0) begin
                    sel = live[$urandom_range(0, live.size() - 1)];
                    act = ACT_RELEASE;
                    b   = tbl_base[sel];
                    c   = tbl_count[sel];
                    if (pick >= 10 + rel_share) begin
                        // near miss on base or count
                        if ($urandom_range(0, 1) == 0) b = b + 16'd1;
                        else                           c = c - 8'd1;
                    end
                end else begin
                    act = ACT_RESERVE;
                    b   = window + 16'($urandom_range(0, 1023));
                    sel = $urandom_range(0, 9);
                    c   = (sel == 0) ? 8'h00 :
                          (sel == 1) ? 8'hFF : 8'($urandom_range(1, 40));
                end
                issue_word(act, b, c);
            end
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // Release every stored range in random order; count must fall to zero.
    task automatic test_release_all();
        int live [$];
        int sel;
        while (slots_in_use() != 0) begin
            live.delete();
            for (int i = 0; i < TB_SLOTS; i++) begin
                if (tbl_valid[i]) live.push_back(i);
            end
            sel = live[$urandom_range(0, live.size() - 1)];
            issue_word(ACT_RELEASE, tbl_base[sel], tbl_count[sel]);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : regression
        fail_count = 0;
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        for (int i = 0; i < TB_SLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_base[i]  = 16'h0000;
            tbl_count[i] = 8'h00;
        end
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_action      <= ACT_RESERVE;
        i_range_base  <= 16'h0000;
        i_range_count <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_ranges();
        test_full_table();
        test_random_traffic();
        test_release_all();
        i_valid <= 1'b0;

        // all replies in, then a short quiet window to catch stray words
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_replies.size() != 0)
            note_failure($sformatf("%0d replies never arrived", expected_replies.size()));

        if (fail_count == 0)
            $display("io_port_range_reservation_table regression: pass");
        else
            $display("io_port_range_reservation_table regression: fail");
        $finish;
    end

endmodule

FILE: io_port_range_reservation_table.f
rtl/iprrt_pkg.sv
rtl/iprrt_front.sv
rtl/iprrt_back.sv
rtl/io_port_range_reservation_table.sv
verif/tb_io_port_range_reservation_table.sv
